// ===== src/round_robin_tick_scheduler_macros.svh =====
// Assertion macros for the round-robin tick scheduler checker.
`ifndef ROUND_ROBIN_TICK_SCHEDULER_MACROS_SVH
`define ROUND_ROBIN_TICK_SCHEDULER_MACROS_SVH

// Plain property check, sampled on clk and quiet during rst.
`define RRTS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check that must hold in the cycle after the output stalls.
`define RRTS_ASSERT_STALL(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) \
    (m_tvalid && !m_tready) |=> prop) else $error(msg);

`endif

// ===== src/rrts_pkg.sv =====
// Shared types and constants for the round-robin tick scheduler.
`timescale 1ns / 1ps
package rrts_pkg;

  localparam int MAX_PROCS_DEFAULT = 16;
  localparam int ID_W      = 4;
  localparam int NUM_IDS   = 16;
  localparam int BURST_W   = 8;
  localparam int QUANTUM_W = 8;
  localparam int TIME_W    = 16;

  localparam logic [QUANTUM_W-1:0] QUANTUM_RESET = 8'd2;
  localparam logic [TIME_W-1:0]    TIME_MAX      = 16'hFFFF;

  localparam int S_TDATA_W = 16;
  localparam int M_TDATA_W = 40;
  localparam int M_TUSER_W = 2;

  typedef struct packed {
    logic               valid;
    logic [ID_W-1:0]    id;
    logic [BURST_W-1:0] burst;
  } arrival_t;

  typedef struct packed {
    logic              busy_res;
    logic [ID_W-1:0]   run_id;
    logic              finished;
    logic [TIME_W-1:0] wait_time;
    logic [TIME_W-1:0] turnaround_time;
    logic              arrival_dropped;
  } result_t;

endpackage

// ===== src/round_robin_tick_scheduler.sv =====
// Top level of the round-robin tick scheduler: stream ports, quantum register, staging.
//
//  channel   | ports                          | payload
//  ----------+--------------------------------+-------------------------------------
//  in  (tick)| s_tvalid s_tready s_tdata      | s_tuser: arrive_valid
//            | s_tuser                        | s_tdata: arrive_id, arrive_burst
//  out (res) | m_tvalid m_tready m_tdata      | m_tuser: busy_res, finished
//            | m_tuser                        | m_tdata: run_id, wait_time,
//            |                                |   turnaround_time, arrival_dropped
//  config    | cfg_wr_en cfg_wr_data          | time_quantum
//
// Each transaction is one time unit. It lands in an input register, the whole tick
// (enqueue, requeue, run of the head, time math) resolves combinationally against the
// scheduler state, and the result is captured in the output register; one transaction
// per cycle is sustained while m_tready holds.
// The input register takes a new transaction whenever it is empty or moves on, so a
// result waiting on m_tready does not stop the next tick from being staged.
// Reset clears the queue pointers, slice, time and the quantum (to 2); the tables need
// no clearing pass, so the block is ready as soon as reset is released.
`timescale 1ns / 1ps
module round_robin_tick_scheduler #(
  parameter int MAX_PROCS = rrts_pkg::MAX_PROCS_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  // tick input
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [rrts_pkg::S_TDATA_W-1:0]     s_tdata,   // [3:0] arrive_id, [11:4] arrive_burst
  input  logic                               s_tuser,   // [0] arrive_valid
  // result output
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [rrts_pkg::M_TDATA_W-1:0]     m_tdata,   // [3:0] run_id, [19:4] wait_time,
                                                        // [35:20] turnaround_time,
                                                        // [36] arrival_dropped
  output logic [rrts_pkg::M_TUSER_W-1:0]     m_tuser,   // [0] busy_res, [1] finished
  // quantum register write
  input  logic                               cfg_wr_en,
  input  logic [rrts_pkg::QUANTUM_W-1:0]     cfg_wr_data
);
  import rrts_pkg::*;

  logic [QUANTUM_W-1:0] quantum;

  // Input stage.
  logic     in_v;
  arrival_t in_item;

  // Output stage.
  result_t  res_comb;
  result_t  res_reg;
  logic     out_v;

  logic     fire;

  // Advance a staged tick when the output register is free or being drained.
  assign fire     = in_v && (!out_v || m_tready);
  assign s_tready = !in_v || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      quantum <= QUANTUM_RESET;
    end else if (cfg_wr_en) begin
      quantum <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_v <= 1'b0;
    end else if (s_tready) begin
      in_v <= s_tvalid;
    end
  end

  // Payload holds while stalled; no reset needed.
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item.valid <= s_tuser;
      in_item.id    <= s_tdata[ID_W-1:0];
      in_item.burst <= s_tdata[ID_W +: BURST_W];
    end
  end

  rrts_sched #(
    .MAX_PROCS (MAX_PROCS)
  ) u_sched (
    .clk     (clk),
    .rst     (rst),
    .tick    (fire),
    .arr     (in_item),
    .quantum (quantum),
    .res     (res_comb)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (fire) begin
      out_v <= 1'b1;
    end else if (m_tready) begin
      out_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_reg <= res_comb;
    end
  end

  assign m_tvalid = out_v;
  assign m_tdata  = {3'b000, res_reg.arrival_dropped, res_reg.turnaround_time,
                     res_reg.wait_time, res_reg.run_id};
  assign m_tuser  = {res_reg.finished, res_reg.busy_res};

endmodule

// ===== src/rrts_sched.sv =====
// Scheduler state and the single-tick update: ready queue, per-id tables, slice and time.
`timescale 1ns / 1ps
module rrts_sched #(
  parameter int MAX_PROCS = rrts_pkg::MAX_PROCS_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               tick,
  input  rrts_pkg::arrival_t                 arr,
  input  logic [rrts_pkg::QUANTUM_W-1:0]     quantum,
  output rrts_pkg::result_t                  res
);
  import rrts_pkg::*;

  localparam int IDX_W = (MAX_PROCS > 2) ? $clog2(MAX_PROCS) : 1;
  localparam int CNT_W = $clog2(MAX_PROCS + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_PROCS - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(MAX_PROCS);
  localparam logic [CNT_W:0]   FULL_OCC = (CNT_W + 1)'(MAX_PROCS);

  // Ready queue and per-id tables; contents are meaningless until written.
  logic [ID_W-1:0]    queue [MAX_PROCS];
  logic [BURST_W-1:0] rem_tab [NUM_IDS];
  logic [BURST_W-1:0] burst_tab [NUM_IDS];
  logic [TIME_W-1:0]  arr_tab [NUM_IDS];

  logic [IDX_W-1:0]     head, head_next;
  logic [IDX_W-1:0]     tail, tail1, tail2;
  logic [CNT_W-1:0]     count, count1, count2, count_next;
  logic [QUANTUM_W-1:0] slice, slice_next;
  logic [TIME_W-1:0]    ctime;
  logic                 rq_pending, rq_pending_next;
  logic [ID_W-1:0]      rq_id, rq_id_next;

  logic                 drop, take, push_rq;
  logic [BURST_W-1:0]   burst_eff;
  logic [ID_W-1:0]      head_id;
  logic                 hit;
  logic [BURST_W-1:0]   rem_cur, burst_cur, rem_dec;
  logic [TIME_W-1:0]    arr_cur, done, tat, wt;
  logic [QUANTUM_W-1:0] q_eff, sl, sl_dec;
  logic                 rem_wr;

  function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] i);
    return (i == LAST_IDX) ? '0 : i + 1'b1;
  endfunction

  always_comb begin
    // Arrival goes in first, holding one slot back for a pending requeue.
    drop      = arr.valid && (((CNT_W + 1)'(count) + (CNT_W + 1)'(rq_pending)) >= FULL_OCC);
    take      = arr.valid && !drop;
    burst_eff = (arr.burst == '0) ? BURST_W'(1) : arr.burst;
    tail1     = take ? idx_inc(tail) : tail;
    count1    = count + CNT_W'(take);
    push_rq   = rq_pending && (count1 != FULL_CNT);
    tail2     = push_rq ? idx_inc(tail1) : tail1;
    count2    = count1 + CNT_W'(push_rq);

    // Forward the pushed id when the queue was empty at the start of the tick.
    head_id   = (count != '0) ? queue[head] : (take ? arr.id : rq_id);
    hit       = take && (arr.id == head_id);
    rem_cur   = hit ? burst_eff : rem_tab[head_id];
    burst_cur = hit ? burst_eff : burst_tab[head_id];
    arr_cur   = hit ? ctime : arr_tab[head_id];

    q_eff     = (quantum == '0) ? QUANTUM_W'(1) : quantum;
    sl        = (slice == '0) ? q_eff : slice;
    sl_dec    = sl - 1'b1;
    rem_dec   = rem_cur - 1'b1;

    done      = (ctime != TIME_MAX) ? ctime + 1'b1 : ctime;
    tat       = (done >= arr_cur) ? done - arr_cur : '0;
    wt        = (tat >= TIME_W'(burst_cur)) ? tat - TIME_W'(burst_cur) : '0;

    head_next       = head;
    count_next      = count2;
    slice_next      = slice;
    rq_pending_next = 1'b0;
    rq_id_next      = rq_id;
    rem_wr          = 1'b0;
    res             = '0;
    res.arrival_dropped = drop;

    if (count2 != '0) begin
      if (rem_cur == '0) begin
        // Stale entry left by a repeated id: drop it without running.
        head_next  = idx_inc(head);
        count_next = count2 - 1'b1;
        slice_next = '0;
      end else begin
        res.busy_res = 1'b1;
        res.run_id   = head_id;
        rem_wr       = 1'b1;
        slice_next   = sl_dec;
        if (rem_dec == '0) begin
          res.finished        = 1'b1;
          res.turnaround_time = tat;
          res.wait_time       = wt;
          head_next           = idx_inc(head);
          count_next          = count2 - 1'b1;
          slice_next          = '0;
        end else if (sl_dec == '0) begin
          head_next       = idx_inc(head);
          count_next      = count2 - 1'b1;
          rq_pending_next = 1'b1;
          rq_id_next      = head_id;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head       <= '0;
      tail       <= '0;
      count      <= '0;
      slice      <= '0;
      ctime      <= '0;
      rq_pending <= 1'b0;
      rq_id      <= '0;
    end else if (tick) begin
      head       <= head_next;
      tail       <= tail2;
      count      <= count_next;
      slice      <= slice_next;
      ctime      <= (ctime != TIME_MAX) ? ctime + 1'b1 : ctime;
      rq_pending <= rq_pending_next;
      rq_id      <= rq_id_next;
    end
  end

  always_ff @(posedge clk) begin
    if (tick) begin
      if (take) begin
        queue[tail]       <= arr.id;
        burst_tab[arr.id] <= burst_eff;
        arr_tab[arr.id]   <= ctime;
      end
      // The run update wins over a same-tick arrival for the same id.
      if (take && !(rem_wr && hit)) begin
        rem_tab[arr.id] <= burst_eff;
      end
      if (push_rq) begin
        queue[tail1] <= rq_id;
      end
      if (rem_wr) begin
        rem_tab[head_id] <= rem_dec;
      end
    end
  end

endmodule

// ===== src/rrts_check.sv =====
// Port-level checker for the round-robin tick scheduler, bound to the top level.
`timescale 1ns / 1ps
`include "round_robin_tick_scheduler_macros.svh"
module rrts_check (
  input logic                               clk,
  input logic                               rst,
  input logic                               m_tvalid,
  input logic                               m_tready,
  input logic [rrts_pkg::M_TDATA_W-1:0]     m_tdata,
  input logic [rrts_pkg::M_TUSER_W-1:0]     m_tuser
);

  // A stalled result stays put.
  `RRTS_ASSERT_STALL(a_out_hold, (m_tvalid && $stable(m_tdata) && $stable(m_tuser)), "result changed while stalled")

  // Only a process that ran can finish.
  `RRTS_ASSERT(a_fin_busy, ((m_tvalid && m_tuser[1]) |-> m_tuser[0]), "finished without a run")

  // An idle tick reports no process.
  `RRTS_ASSERT(a_idle_id, ((m_tvalid && !m_tuser[0]) |-> (m_tdata[3:0] == 4'd0)), "idle tick with a run id")

  // Times are zero unless a process finished, and waiting never exceeds turnaround.
  `RRTS_ASSERT(a_times_zero, ((m_tvalid && !m_tuser[1]) |-> (m_tdata[35:4] == 32'd0)), "times without completion")
  `RRTS_ASSERT(a_wait_le_tat, ((m_tvalid && m_tuser[1]) |-> (m_tdata[19:4] <= m_tdata[35:20])), "wait above turnaround")

endmodule

bind round_robin_tick_scheduler rrts_check u_rrts_check (.*);
